>>> rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the coalescing bounded fifo
// Field widths, push status codes, the stored entry layout and reset values.
// ----------------------------------------------------------------------------
package cbf_pkg;

	// field widths fixed by the item format
	localparam int SLOT_W = 8;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam int STAT_W = 2;

	// default queue depth and capacity after reset
	localparam int DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// push outcome
	typedef enum logic [STAT_W-1:0] {
		ST_ADDED     = 2'd0,
		ST_COALESCED = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// one queued entry: key (slot, state) and payload
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              occ;
		logic [DATA_W-1:0] data;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/cbf_if.sv
// ----------------------------------------------------------------------------
// cbf_if: command and result channels of the coalescing bounded fifo
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface cbf_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [cbf_pkg::SLOT_W-1:0] slot_id;
	logic                       occupied;
	logic [cbf_pkg::DATA_W-1:0] payload;

	modport source (output valid, opcode, slot_id, occupied, payload, input ready);
	modport sink   (input valid, opcode, slot_id, occupied, payload, output ready);
endinterface

interface cbf_res_if #(
	parameter int CNT_W = 5
);
	logic                       valid;
	logic                       ready;
	logic [cbf_pkg::STAT_W-1:0] push_status;
	logic                       pop_valid;
	logic [cbf_pkg::SLOT_W-1:0] out_slot_id;
	logic                       out_occupied;
	logic [cbf_pkg::DATA_W-1:0] out_payload;
	logic [CNT_W-1:0]           count;

	modport source (output valid, push_status, pop_valid, out_slot_id, out_occupied,
		out_payload, count, input ready);
	modport sink   (input valid, push_status, pop_valid, out_slot_id, out_occupied,
		out_payload, count, output ready);
endinterface

>>> rtl/cbf_entry_ram.sv
// ----------------------------------------------------------------------------
// cbf_entry_ram: entry storage of the coalescing bounded fifo
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbf_entry_ram #(
	parameter int DEPTH  = cbf_pkg::DEPTH_DEF,
	parameter int ADDR_W = 4,
	parameter int WIDTH  = cbf_pkg::ENTRY_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/coalescing_bounded_fifo.sv
// ----------------------------------------------------------------------------
// coalescing_bounded_fifo: fifo of keyed work items with in-place coalescing
// A push replaces the payload of a queued entry with the same key, else
// appends within the capacity; a pop returns the oldest entry.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time. A push walks the queued entries
// oldest first through one read port of the entry memory and one key
// comparator, one entry per cycle, so it holds the command channel from
// acceptance until the walk ends, sooner when it coalesces early. Pushes
// and pops are both held longer while the previous result still waits in
// the output register. One result comes back per command through an output
// register, and the next command is taken while that result still waits.
// The user must see that capacity is written through capacity_we/capacity_wdata
// only while the block is idle; the block itself does not enforce it. Zero
// acts as one and values above DEPTH act as DEPTH. The entry memory needs no
// clearing after reset.
module coalescing_bounded_fifo #(
	parameter int DEPTH = cbf_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      capacity_we,
	input  logic [cbf_pkg::CAP_W-1:0] capacity_wdata,
	cbf_cmd_if.sink                   cmd,
	cbf_res_if.source                 res
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = (CNT_W > cbf_pkg::CAP_W) ? CNT_W : cbf_pkg::CAP_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_POPW = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [cbf_pkg::CAP_W-1:0] cap_q;
	logic [IDX_W-1:0]          head_q, tail_q, ptr_q, rd_ptr_s1;
	logic [CNT_W-1:0]          count_q, issued_q;
	logic                      rd_vld_s1;

	// latched command
	logic                      op_q;
	cbf_pkg::entry_t           item_q;

	// pending result and output register
	cbf_pkg::status_t          r_status_q;
	logic                      r_popv_q;
	cbf_pkg::entry_t           r_entry_q;
	cbf_pkg::status_t          o_status_q;
	logic                      o_popv_q;
	cbf_pkg::entry_t           o_entry_q;
	logic [CNT_W-1:0]          o_count_q;
	logic                      o_valid_q;

	// memory port signals
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr, ram_raddr;
	logic [cbf_pkg::ENTRY_W-1:0] ram_rdata;
	cbf_pkg::entry_t           rd_entry;

	logic                      cmd_fire, scan_issue, scan_hit, scan_miss, q_full, out_free;
	logic [CMP_W-1:0]          eff_cap, cap_ext, count_ext;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
		next_idx = (x == IDX_W'(DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	// entry storage
	cbf_entry_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (IDX_W),
		.WIDTH  (cbf_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = cbf_pkg::entry_t'(ram_rdata);

	// capacity clamped to the range one to DEPTH
	assign cap_ext   = CMP_W'(cap_q);
	assign count_ext = CMP_W'(count_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign q_full = (count_ext >= eff_cap);

	// scan control: one read issued and one key compared per cycle
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign scan_hit   = (state_q == S_SCAN) && rd_vld_s1 &&
		(rd_entry.slot == item_q.slot) && (rd_entry.occ == item_q.occ);
	assign scan_issue = (state_q == S_SCAN) && (issued_q != count_q) && !scan_hit;
	assign scan_miss  = (state_q == S_SCAN) && !rd_vld_s1 && (issued_q == count_q);

	// memory addressing: head during idle for pops, walking pointer during scan
	assign ram_raddr = (state_q == S_SCAN) ? ptr_q : head_q;
	assign ram_we    = scan_hit || (scan_miss && !q_full);
	assign ram_waddr = scan_hit ? rd_ptr_s1 : tail_q;

	assign out_free  = !o_valid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cbf_pkg::CAP_RESET;
		end else if (capacity_we) begin
			cap_q <= capacity_wdata;
		end
	end

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						if (cmd.opcode == cbf_pkg::OP_PUSH) begin
							state_q <= S_SCAN;
						end else if (count_q != '0) begin
							state_q <= S_POPW;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_DONE;
					end else if (scan_miss) begin
						if (!q_full) begin
							tail_q  <= next_idx(tail_q);
							count_q <= count_q + 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_POPW: begin
					head_q  <= next_idx(head_q);
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command latch and scan walk
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q     <= cmd.opcode;
			item_q   <= '{slot: cmd.slot_id, occ: cmd.occupied, data: cmd.payload};
			ptr_q    <= head_q;
			issued_q <= '0;
		end else if (scan_issue) begin
			ptr_q    <= next_idx(ptr_q);
			issued_q <= issued_q + 1'b1;
		end
		if (scan_issue) begin
			rd_ptr_s1 <= ptr_q;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			r_status_q <= cbf_pkg::ST_ADDED;
			r_popv_q   <= 1'b0;
			r_entry_q  <= '0;
		end else if (scan_hit) begin
			r_status_q <= cbf_pkg::ST_COALESCED;
		end else if (scan_miss) begin
			r_status_q <= q_full ? cbf_pkg::ST_FULL : cbf_pkg::ST_ADDED;
		end else if (state_q == S_POPW) begin
			r_popv_q  <= 1'b1;
			r_entry_q <= rd_entry;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			o_valid_q <= 1'b1;
		end else if (res.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			o_status_q <= r_status_q;
			o_popv_q   <= r_popv_q;
			o_entry_q  <= r_entry_q;
			o_count_q  <= count_q;
		end
	end

	assign res.valid        = o_valid_q;
	assign res.push_status  = o_status_q;
	assign res.pop_valid    = o_popv_q;
	assign res.out_slot_id  = o_entry_q.slot;
	assign res.out_occupied = o_entry_q.occ;
	assign res.out_payload  = o_entry_q.data;
	assign res.count        = o_count_q;

`ifndef SYNTHESIS
	// the queue never holds more than DEPTH entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	// the count moves by at most one entry per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 ((count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
		(count_q == $past(count_q) - 1'b1)))
		else $error("queue count jumped");

	// entry memory is written only by a push during its scan
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_SCAN) && (op_q == cbf_pkg::OP_PUSH)))
		else $error("entry write outside a push scan");

	// a pop result carries the default push status ST_ADDED
	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_popv_q) |-> (o_status_q == cbf_pkg::ST_ADDED))
		else $error("pop result with push status");
`endif

endmodule

>>> bench/tb_coalescing_bounded_fifo.sv
// ----------------------------------------------------------------------------
// tb_coalescing_bounded_fifo: self-checking bench of the coalescing fifo
// Drives push and pop commands with random gaps on both channels, predicts
// every result with a shadow queue of keyed entries, and compares each result
// field by field in arrival order, over several capacity settings.
// ----------------------------------------------------------------------------
module tb_coalescing_bounded_fifo;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH = cbf_pkg::DEPTH_DEF;
	localparam int CNT_W      = 5;
	localparam int SLOT_W     = cbf_pkg::SLOT_W;
	localparam int DATA_W     = cbf_pkg::DATA_W;
	localparam int CAP_W      = cbf_pkg::CAP_W;
	localparam int KEY_W      = cbf_pkg::SLOT_W + 1;
	localparam int POOL_N     = 32;
	localparam int POOL_IDX_W = 5;

	// one expected result
	typedef struct {
		cbf_pkg::status_t  status;
		logic              pop_valid;
		logic [SLOT_W-1:0] slot;
		logic              occ;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} fifo_resp_t;

	logic             clk;
	logic             arst_n;
	logic             capacity_we;
	logic [CAP_W-1:0] capacity_wdata;

	cbf_cmd_if                   cmd_bus ();
	cbf_res_if #(.CNT_W(CNT_W))  res_bus ();

	coalescing_bounded_fifo #(
		.DEPTH (FIFO_DEPTH),
		.CNT_W (CNT_W)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.cmd            (cmd_bus.sink),
		.res            (res_bus.source)
	);

	// shadow copy of the queue and its capacity
	logic [SLOT_W-1:0] shadow_slot [FIFO_DEPTH];
	logic              shadow_occ  [FIFO_DEPTH];
	logic [DATA_W-1:0] shadow_data [FIFO_DEPTH];
	int unsigned       shadow_head;
	int unsigned       shadow_fill;
	logic [CAP_W-1:0]  shadow_cap;

	fifo_resp_t expected_resps [$];

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned error_count;
	int unsigned n_added, n_coalesced, n_full, n_pop_hit, n_pop_empty, n_cap_writes;

	// key pool for random traffic, so that coalescing and full queues happen
	logic [KEY_W-1:0] key_pool [POOL_N];
	int unsigned      pool_size;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#10ms;
		$display("tb_coalescing_bounded_fifo failed");
		$finish;
	end

	// works out the result of one accepted command and updates the shadow queue
	function automatic fifo_resp_t predict_resp(logic op, logic [SLOT_W-1:0] slot,
		logic occ, logic [DATA_W-1:0] data);
		fifo_resp_t  r;
		int unsigned limit;
		int unsigned pos;
		int unsigned i;
		bit          hit;

		r.status    = cbf_pkg::ST_ADDED;
		r.pop_valid = 1'b0;
		r.slot      = '0;
		r.occ       = 1'b0;
		r.data      = '0;
		hit         = 1'b0;
		limit       = (shadow_cap == '0) ? 1 :
			((int'(shadow_cap) > FIFO_DEPTH) ? FIFO_DEPTH : int'(shadow_cap));

		if (op == cbf_pkg::OP_PUSH) begin
			// oldest first search for the same key
			for (i = 0; i < shadow_fill; i++) begin
				pos = (shadow_head + i) % FIFO_DEPTH;
				if (!hit && shadow_slot[pos] == slot && shadow_occ[pos] == occ) begin
					shadow_data[pos] = data;
					hit = 1'b1;
				end
			end
			if (hit) begin
				r.status = cbf_pkg::ST_COALESCED;
				n_coalesced++;
			end else if (shadow_fill >= limit) begin
				r.status = cbf_pkg::ST_FULL;
				n_full++;
			end else begin
				pos = (shadow_head + shadow_fill) % FIFO_DEPTH;
				shadow_slot[pos] = slot;
				shadow_occ[pos]  = occ;
				shadow_data[pos] = data;
				shadow_fill++;
				n_added++;
			end
		end else if (shadow_fill > 0) begin
			r.pop_valid = 1'b1;
			r.slot      = shadow_slot[shadow_head];
			r.occ       = shadow_occ[shadow_head];
			r.data      = shadow_data[shadow_head];
			shadow_head = (shadow_head + 1) % FIFO_DEPTH;
			shadow_fill--;
			n_pop_hit++;
		end else begin
			n_pop_empty++;
		end
		r.count = shadow_fill[CNT_W-1:0];
		return r;
	endfunction

	// sends one command; entered and left at a falling edge
	task automatic send_cmd(logic op, logic [SLOT_W-1:0] slot, logic occ,
		logic [DATA_W-1:0] data);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid    <= 1'b1;
		cmd_bus.opcode   <= op;
		cmd_bus.slot_id  <= slot;
		cmd_bus.occupied <= occ;
		cmd_bus.payload  <= data;
		do @(posedge clk); while (!cmd_bus.ready);
		expected_resps.insert(expected_resps.size(), predict_resp(op, slot, occ, data));
		@(negedge clk);
	endtask

	// stops sending and waits until every result has come back
	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		while (expected_resps.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// capacity register write while the block is idle
	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		capacity_we    <= 1'b1;
		capacity_wdata <= value;
		@(negedge clk);
		capacity_we <= 1'b0;
		shadow_cap = value;
		n_cap_writes++;
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
		if (act_v !== exp_v) begin
			error_count++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
		end
	endtask

	// result sink: random back-pressure
	always @(negedge clk)
		res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// result checker
	always @(posedge clk) begin
		fifo_resp_t exp_r;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_resps.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result transaction: expected none, actual status %0d count %0d",
					$time, res_bus.push_status, res_bus.count);
			end else begin
				exp_r = expected_resps[0];
				expected_resps.delete(0);
				check_field("push_status", DATA_W'(exp_r.status), DATA_W'(res_bus.push_status));
				check_field("pop_valid", DATA_W'(exp_r.pop_valid), DATA_W'(res_bus.pop_valid));
				check_field("out_slot_id", DATA_W'(exp_r.slot), DATA_W'(res_bus.out_slot_id));
				check_field("out_occupied", DATA_W'(exp_r.occ), DATA_W'(res_bus.out_occupied));
				check_field("out_payload", exp_r.data, res_bus.out_payload);
				check_field("count", DATA_W'(exp_r.count), DATA_W'(res_bus.count));
			end
		end
	end

	// extremes of the fields, coalescing, a pop on an empty queue
	task automatic test_basic_ops();
		send_cmd(cbf_pkg::OP_POP, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		send_cmd(cbf_pkg::OP_PUSH, 8'h00, 1'b0, 32'h0000_0000);
		send_cmd(cbf_pkg::OP_PUSH, 8'hFF, 1'b1, 32'hFFFF_FFFF);
		send_cmd(cbf_pkg::OP_PUSH, 8'hFF, 1'b0, 32'hA5A5_A5A5);
		send_cmd(cbf_pkg::OP_PUSH, 8'hFF, 1'b1, 32'h5A5A_5A5A);
		send_cmd(cbf_pkg::OP_PUSH, 8'h00, 1'b0, 32'h1234_5678);
		send_cmd(cbf_pkg::OP_POP, 8'h00, 1'b0, 32'h0000_0000);
	endtask

	// capacity below count, capacity zero, coalescing on a full queue
	task automatic test_capacity_limits();
		write_capacity(5'd2);
		send_cmd(cbf_pkg::OP_PUSH, 8'h3C, 1'b1, 32'hDEAD_BEEF);
		send_cmd(cbf_pkg::OP_PUSH, 8'hFF, 1'b0, 32'hC0DE_0001);
		write_capacity(5'd0);
		send_cmd(cbf_pkg::OP_PUSH, 8'h81, 1'b0, 32'h0000_0001);
		send_cmd(cbf_pkg::OP_POP, 8'h00, 1'b0, 32'h0000_0000);
		send_cmd(cbf_pkg::OP_PUSH, 8'h81, 1'b0, 32'h0000_0002);
		send_cmd(cbf_pkg::OP_POP, 8'h00, 1'b0, 32'h0000_0000);
		send_cmd(cbf_pkg::OP_PUSH, 8'h81, 1'b1, 32'h0000_0003);
		send_cmd(cbf_pkg::OP_PUSH, 8'h81, 1'b1, 32'h8000_0000);
		send_cmd(cbf_pkg::OP_PUSH, 8'h7E, 1'b0, 32'h0000_0004);
		send_cmd(cbf_pkg::OP_POP, 8'h00, 1'b0, 32'h0000_0000);
		write_capacity(5'd31);
	endtask

	// fill to DEPTH, coalesce while full, drain past empty
	task automatic test_fill_and_drain();
		int unsigned k;
		for (k = 0; k < FIFO_DEPTH; k++)
			send_cmd(cbf_pkg::OP_PUSH, 8'(k * 17), k[0], $urandom);
		send_cmd(cbf_pkg::OP_PUSH, 8'hEE, 1'b0, $urandom);
		send_cmd(cbf_pkg::OP_PUSH, 8'(15 * 17), 1'b1, $urandom);
		for (k = 0; k <= FIFO_DEPTH; k++)
			send_cmd(cbf_pkg::OP_POP, SLOT_W'($urandom), 1'($urandom), $urandom);
	endtask

	// random traffic, swinging between push-heavy and pop-heavy stretches
	task automatic test_random_traffic(int unsigned n_items);
		int unsigned       k;
		int unsigned       push_pct;
		logic [SLOT_W-1:0] s;
		logic              o;

		pool_size = $urandom_range(3, 20);
		for (k = 0; k < pool_size; k++)
			key_pool[k] = KEY_W'($urandom);
		push_pct = 60;
		for (k = 0; k < n_items; k++) begin
			if (k % 32 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 25;
				endcase
			end
			if ($urandom_range(0, 99) < push_pct) begin
				if ($urandom_range(0, 99) < 75) begin
					{s, o} = key_pool[POOL_IDX_W'($urandom_range(0, pool_size - 1))];
				end else begin
					s = SLOT_W'($urandom);
					o = 1'($urandom);
				end
				send_cmd(cbf_pkg::OP_PUSH, s, o, $urandom);
			end else begin
				send_cmd(cbf_pkg::OP_POP, SLOT_W'($urandom), 1'($urandom), $urandom);
			end
		end
	endtask

	// test sequence
	initial begin
		arst_n           = 1'b0;
		capacity_we      = 1'b0;
		capacity_wdata   = '0;
		cmd_bus.valid    = 1'b0;
		cmd_bus.opcode   = cbf_pkg::OP_PUSH;
		cmd_bus.slot_id  = '0;
		cmd_bus.occupied = 1'b0;
		cmd_bus.payload  = '0;
		tx_idle_pct      = 26;
		rx_idle_pct      = 86;
		error_count      = 0;
		n_added          = 0;
		n_coalesced      = 0;
		n_full           = 0;
		n_pop_hit        = 0;
		n_pop_empty      = 0;
		n_cap_writes     = 0;
		shadow_head      = 0;
		shadow_fill      = 0;
		shadow_cap       = cbf_pkg::CAP_RESET;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// slow receiver
		test_basic_ops();
		test_capacity_limits();
		test_fill_and_drain();
		write_capacity(5'd16);
		test_random_traffic(250);
		write_capacity(5'd3);
		test_random_traffic(150);

		// slow sender
		wait_idle();
		tx_idle_pct = 86;
		rx_idle_pct = 26;
		write_capacity(5'd31);
		test_random_traffic(250);
		write_capacity(5'd1);
		test_random_traffic(120);

		// back to back
		wait_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_capacity(5'($urandom_range(2, 15)));
		test_random_traffic(300);
		write_capacity(5'd0);
		test_random_traffic(100);
		write_capacity(5'd16);
		test_random_traffic(250);

		wait_idle();
		repeat (25) @(negedge clk);

		$display("covered: %0d added, %0d coalesced, %0d full pushes", n_added, n_coalesced, n_full);
		$display("covered: %0d pops with data, %0d on empty, %0d capacity writes",
			n_pop_hit, n_pop_empty, n_cap_writes);
		if (error_count == 0 && expected_resps.size() == 0)
			$display("tb_coalescing_bounded_fifo passed");
		else
			$display("tb_coalescing_bounded_fifo failed");
		$finish;
	end

endmodule

>>> coalescing_bounded_fifo.f
rtl/cbf_pkg.sv
rtl/cbf_if.sv
rtl/cbf_entry_ram.sv
rtl/coalescing_bounded_fifo.sv
bench/tb_coalescing_bounded_fifo.sv
